@@ design/energy_vad_hangover_top_assert.svh @@
// assertion macros used by the checker file
`ifndef ENERGY_VAD_HANGOVER_TOP_ASSERT_SVH
`define ENERGY_VAD_HANGOVER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define EVAD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("evad assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define EVAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("evad assertion failed");

`endif

@@ design/evad_pkg.sv @@
// ----------------------------------------------------------------------------
// evad_pkg
// Types and constants shared by the energy voice activity detector modules.
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int ENERGY_BITS   = 48;
  localparam int SAMPLE_BITS   = 16;
  localparam int SQ_BITS       = 31;
  localparam int PROB_BITS     = 9;
  localparam int QUO_BITS      = 8;
  localparam int DIV_BITS      = ENERGY_BITS + 2;
  localparam int CNT_BITS      = 3;
  localparam int ALPHA_BITS    = 16;
  localparam int FRAME_BITS    = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 48;

  localparam logic [ENERGY_BITS-1:0] ENERGY_MAX  = '1;
  localparam logic [ENERGY_BITS-1:0] NOISE_RESET = 48'd134217728;
  localparam logic [PROB_BITS-1:0]   PROB_FULL   = 9'd256;

  localparam logic [ALPHA_BITS-1:0]  ALPHA_RISE_RESET = 16'd3277;
  localparam logic [ALPHA_BITS-1:0]  ALPHA_FALL_RESET = 16'd9830;
  localparam logic [ALPHA_BITS-1:0]  LOW_RATIO_RESET  = 16'd39322;
  localparam logic [FRAME_BITS-1:0]  HANGOVER_RESET   = 8'd8;
  localparam logic [FRAME_BITS-1:0]  WARMUP_RESET     = 8'd12;
  localparam logic [ENERGY_BITS-1:0] NF_MIN_RESET     = 48'd134217728;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ALPHA_RISE = 3'd0,
    CFG_ALPHA_FALL = 3'd1,
    CFG_LOW_RATIO  = 3'd2,
    CFG_HANGOVER   = 3'd3,
    CFG_WARMUP     = 3'd4,
    CFG_NF_MIN     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ALPHA_BITS-1:0]  alpha_rise;
    logic [ALPHA_BITS-1:0]  alpha_fall;
    logic [ALPHA_BITS-1:0]  low_ratio;
    logic [FRAME_BITS-1:0]  hangover;
    logic [FRAME_BITS-1:0]  warmup;
    logic [ENERGY_BITS-1:0] nf_min;
  } cfg_t;

  typedef struct packed {
    logic ld_sample;
    logic square;
    logic accum;
    logic decide;
    logic mul_lo;
    logic mul_hi;
    logic update;
    logic smooth;
    logic prep;
    logic pchk;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic early;
    logic upd_en;
    logic prob_skip;
    logic div_last;
    logic out_stall;
  } status_t;

endpackage

@@ design/energy_vad_hangover_top.sv @@
// ----------------------------------------------------------------------------
// energy_vad_hangover_top
// Energy voice activity detector with hangover and Q8 speech probability.
// ----------------------------------------------------------------------------
// Usage:
//   Q15 samples enter on the in channel (sample_i, frame_end_i). Each sample
//   is captured, squared on a 16x16 multiplier and accumulated in turn, and
//   in_ready_o stays low until it is accumulated or its frame is finished.
//   The sample flagged with frame_end_i closes the frame and yields one item
//   on the out channel (speech, probability, frame energy, noise floor).
//   For first and warm-up frames the decision step leads straight to the
//   probability steps; later frames first form the threshold product and
//   update the hangover, then the smoothing product when the noise floor is
//   smoothed; a probability settled without division skips the divider.
//   Each Q16 product is formed in two halves (16x16 low, 32x16 high); a
//   restoring divider gives the 8-bit probability quotient one bit per cycle.
//   Samples without frame_end produce no item. A finished result sits in an
//   output register, so samples keep flowing while the receiver stalls; only
//   the next frame end waits for it to drain. Registers are to be written
//   through the cfg channel (always ready) only while idle; the block does
//   not enforce this. Reset clears the energy and hangover state, restores
//   register defaults and sets the noise floor to the default minimum floor.
// ----------------------------------------------------------------------------
module energy_vad_hangover_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [evad_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                    frame_end_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    speech_o,
  output logic [evad_pkg::PROB_BITS-1:0]          probability_o,
  output logic [evad_pkg::ENERGY_BITS-1:0]        energy_out_o,
  output logic [evad_pkg::ENERGY_BITS-1:0]        noise_out_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [evad_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [evad_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);

  evad_pkg::cfg_t    cfg;
  evad_pkg::cmd_t    cmd;
  evad_pkg::status_t st;

  evad_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  evad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  evad_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .cfg_i         (cfg),
    .sample_i      (sample_i),
    .frame_end_i   (frame_end_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .speech_o      (speech_o),
    .probability_o (probability_o),
    .energy_out_o  (energy_out_o),
    .noise_out_o   (noise_out_o)
  );

endmodule

@@ design/evad_cfg.sv @@
// ----------------------------------------------------------------------------
// evad_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module evad_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [evad_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [evad_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output evad_pkg::cfg_t                       cfg_o
);

  evad_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_rise <= evad_pkg::ALPHA_RISE_RESET;
      cfg_q.alpha_fall <= evad_pkg::ALPHA_FALL_RESET;
      cfg_q.low_ratio  <= evad_pkg::LOW_RATIO_RESET;
      cfg_q.hangover   <= evad_pkg::HANGOVER_RESET;
      cfg_q.warmup     <= evad_pkg::WARMUP_RESET;
      cfg_q.nf_min     <= evad_pkg::NF_MIN_RESET;
    end else if (cfg_valid_i) begin
      // indexes past the list are dropped
      case (cfg_index_i)
        evad_pkg::CFG_ALPHA_RISE: cfg_q.alpha_rise <= cfg_data_i[15:0];
        evad_pkg::CFG_ALPHA_FALL: cfg_q.alpha_fall <= cfg_data_i[15:0];
        evad_pkg::CFG_LOW_RATIO:  cfg_q.low_ratio  <= cfg_data_i[15:0];
        evad_pkg::CFG_HANGOVER:   cfg_q.hangover   <= cfg_data_i[7:0];
        evad_pkg::CFG_WARMUP:     cfg_q.warmup     <= cfg_data_i[7:0];
        evad_pkg::CFG_NF_MIN:     cfg_q.nf_min     <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/evad_ctrl.sv @@
// ----------------------------------------------------------------------------
// evad_ctrl
// Sequencer: sample intake, frame decision steps, divider loop, result hand-off.
// ----------------------------------------------------------------------------
module evad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  evad_pkg::status_t st_i,
  output evad_pkg::cmd_t    cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SQR    = 14'b00000000000010,
    S_ACC    = 14'b00000000000100,
    S_DEC    = 14'b00000000001000,
    S_MLO_A  = 14'b00000000010000,
    S_MHI_A  = 14'b00000000100000,
    S_UPD    = 14'b00000001000000,
    S_MLO_B  = 14'b00000010000000,
    S_MHI_B  = 14'b00000100000000,
    S_SMOOTH = 14'b00001000000000,
    S_PREP   = 14'b00010000000000,
    S_PCHK   = 14'b00100000000000,
    S_DIV    = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_sample = 1'b1;
          state_d         = S_SQR;
        end
      end
      S_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = st_i.frame_end ? S_DEC : S_IDLE;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        // first and warm-up frames skip the detection math
        state_d      = st_i.early ? S_PREP : S_MLO_A;
      end
      S_MLO_A: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI_A;
      end
      S_MHI_A: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = st_i.upd_en ? S_MLO_B : S_PREP;
      end
      S_MLO_B: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI_B;
      end
      S_MHI_B: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_PCHK;
      end
      S_PCHK: begin
        cmd_o.pchk = 1'b1;
        state_d    = st_i.prob_skip ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!st_i.out_stall) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/evad_dp.sv @@
// ----------------------------------------------------------------------------
// evad_dp
// Datapath: energy accumulator, noise tracker, shared Q16 multiplier,
// restoring divider for the probability, and the output register.
// ----------------------------------------------------------------------------
module evad_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  evad_pkg::cmd_t                         cmd_i,
  output evad_pkg::status_t                      st_o,
  input  evad_pkg::cfg_t                         cfg_i,
  input  logic signed [evad_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   frame_end_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   speech_o,
  output logic [evad_pkg::PROB_BITS-1:0]         probability_o,
  output logic [evad_pkg::ENERGY_BITS-1:0]       energy_out_o,
  output logic [evad_pkg::ENERGY_BITS-1:0]       noise_out_o
);

  localparam int EB = evad_pkg::ENERGY_BITS;
  localparam int DB = evad_pkg::DIV_BITS;

  // sample and energy
  logic [evad_pkg::SAMPLE_BITS-1:0] raw, mag, mag_q;
  logic                             fe_q;
  logic [evad_pkg::SQ_BITS-1:0]     sq_q;
  logic [31:0]                      sq_full;
  logic [EB-1:0]                    acc_q, e_q;
  logic [EB:0]                      acc_sum;
  logic [EB-1:0]                    acc_sat;

  // decision state
  logic [EB-1:0]                    noise_q;
  logic [evad_pkg::FRAME_BITS-1:0]  fs_q, fs_new, hold_q;
  logic                             first_q, speech_q, upd_en_q, det_q;

  // multiplier
  logic [EB-1:0]                    x_q;
  logic [evad_pkg::ALPHA_BITS-1:0]  f_q;
  logic [31:0]                      plo_q, plo_full;
  logic [EB-1:0]                    phi_q, phi_full, mres;

  // probability
  logic [EB-1:0]                    d_q;
  logic [DB-1:0]                    m_q, rem_q;
  logic [DB:0]                      r2, r2_sub;
  logic                             zero_q;
  logic [evad_pkg::QUO_BITS-1:0]    quo_q, quo_new;
  logic [evad_pkg::CNT_BITS-1:0]    cnt_q;
  logic [evad_pkg::PROB_BITS-1:0]   prob_q;

  // combinational helpers
  logic                             e_gt_n, low, det_now, upd_en_nx, skip;
  logic [EB-1:0]                    n_step, n_smooth;

  // output register
  logic                             out_valid_q, out_speech_q;
  logic [evad_pkg::PROB_BITS-1:0]   out_prob_q;
  logic [EB-1:0]                    out_e_q, out_n_q;

  assign raw = $unsigned(sample_i);
  assign mag = raw[evad_pkg::SAMPLE_BITS-1] ? (~raw + 16'd1) : raw;

  assign sq_full = 32'(mag_q) * 32'(mag_q);
  assign acc_sum = {1'b0, acc_q} + (EB+1)'(sq_q);
  assign acc_sat = acc_sum[EB] ? evad_pkg::ENERGY_MAX : acc_sum[EB-1:0];

  assign fs_new = (fs_q == 8'hFF) ? fs_q : fs_q + 8'd1;

  assign plo_full = 32'(x_q[15:0]) * 32'(f_q);
  assign phi_full = EB'(x_q[EB-1:16]) * EB'(f_q);
  // floor(x * f / 2^16) from the two partial products
  assign mres     = phi_q + EB'(plo_q[31:16]);

  assign e_gt_n = e_q > noise_q;
  assign low    = e_q < mres;
  assign det_now = det_q && !low;

  always_comb begin
    if (det_now) begin
      upd_en_nx = 1'b0;
    end else if (hold_q != '0) begin
      upd_en_nx = low ? 1'b1 : upd_en_q;
    end else begin
      upd_en_nx = 1'b1;
    end
  end

  assign n_step   = e_gt_n ? (noise_q + mres) : (noise_q - mres);
  assign n_smooth = (n_step < cfg_i.nf_min) ? cfg_i.nf_min : n_step;

  assign skip = zero_q || ({2'b00, d_q} >= m_q);

  assign r2      = {rem_q, 1'b0};
  assign r2_sub  = r2 - {1'b0, m_q};
  assign quo_new = {quo_q[evad_pkg::QUO_BITS-2:0], (r2 >= {1'b0, m_q})};

  assign st_o.frame_end = fe_q;
  assign st_o.early     = first_q || (fs_new < cfg_i.warmup);
  assign st_o.upd_en    = upd_en_nx;
  assign st_o.prob_skip = skip;
  assign st_o.div_last  = (cnt_q == '0);
  assign st_o.out_stall = out_valid_q && !out_ready_i;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sample) begin
      mag_q <= mag;
    end
    if (cmd_i.square) begin
      sq_q <= sq_full[evad_pkg::SQ_BITS-1:0];
    end
    if (cmd_i.accum && fe_q) begin
      e_q <= acc_sat;
    end
    if (cmd_i.decide) begin
      det_q <= {1'b0, e_q} > {noise_q, 1'b0};
      x_q   <= noise_q;
      f_q   <= cfg_i.low_ratio;
    end
    if (cmd_i.update) begin
      x_q <= e_gt_n ? (e_q - noise_q) : (noise_q - e_q);
      f_q <= e_gt_n ? cfg_i.alpha_rise : cfg_i.alpha_fall;
    end
    if (cmd_i.mul_lo) begin
      plo_q <= plo_full;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= phi_full;
    end
    if (cmd_i.prep) begin
      d_q    <= e_q - noise_q;
      m_q    <= DB'(noise_q) + {1'b0, noise_q, 1'b0};
      zero_q <= (noise_q < cfg_i.nf_min) || !e_gt_n;
    end
    if (cmd_i.pchk) begin
      rem_q  <= DB'(d_q);
      quo_q  <= '0;
      cnt_q  <= evad_pkg::CNT_BITS'(evad_pkg::QUO_BITS - 1);
      prob_q <= zero_q ? '0 : evad_pkg::PROB_FULL;
    end
    if (cmd_i.div_step) begin
      rem_q  <= (r2 >= {1'b0, m_q}) ? r2_sub[DB-1:0] : r2[DB-1:0];
      quo_q  <= quo_new;
      cnt_q  <= cnt_q - 1'b1;
      prob_q <= {1'b0, quo_new};
    end
    if (cmd_i.finish) begin
      out_speech_q <= speech_q;
      out_prob_q   <= prob_q;
      out_e_q      <= e_q;
      out_n_q      <= noise_q;
    end
  end

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q     <= 1'b0;
      acc_q    <= '0;
      noise_q  <= evad_pkg::NOISE_RESET;
      fs_q     <= '0;
      first_q  <= 1'b1;
      hold_q   <= '0;
      speech_q <= 1'b0;
      upd_en_q <= 1'b0;
    end else begin
      if (cmd_i.ld_sample) begin
        fe_q <= frame_end_i;
      end
      if (cmd_i.accum) begin
        acc_q <= fe_q ? '0 : acc_sat;
      end
      if (cmd_i.decide) begin
        fs_q <= fs_new;
        if (first_q) begin
          noise_q  <= e_q;
          first_q  <= 1'b0;
          speech_q <= 1'b0;
        end else if (fs_new < cfg_i.warmup) begin
          if (e_gt_n) begin
            noise_q <= e_q;
          end
          speech_q <= 1'b0;
        end
      end
      if (cmd_i.update) begin
        upd_en_q <= upd_en_nx;
        if (det_now) begin
          hold_q   <= cfg_i.hangover;
          speech_q <= 1'b1;
        end else if (hold_q != '0) begin
          hold_q   <= hold_q - 8'd1;
          speech_q <= 1'b1;
        end else begin
          speech_q <= 1'b0;
        end
      end
      if (cmd_i.smooth) begin
        noise_q <= n_smooth;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign speech_o      = out_speech_q;
  assign probability_o = out_prob_q;
  assign energy_out_o  = out_e_q;
  assign noise_out_o   = out_n_q;

endmodule

@@ design/evad_checker.sv @@
// ----------------------------------------------------------------------------
// evad_checker
// Port-level checks on the detector top level, attached by bind.
// ----------------------------------------------------------------------------
`include "energy_vad_hangover_top_assert.svh"

module evad_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               speech_o,
  input logic [evad_pkg::PROB_BITS-1:0]     probability_o,
  input logic [evad_pkg::ENERGY_BITS-1:0]   energy_out_o,
  input logic [evad_pkg::ENERGY_BITS-1:0]   noise_out_o
);

  // stalled result keeps its payload
  `EVAD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(energy_out_o) && $stable(noise_out_o) && $stable(probability_o) && $stable(speech_o))

  `EVAD_ASSERT_IMP(a_prob_range, out_valid_o, probability_o <= evad_pkg::PROB_FULL)

  // nonzero probability only when the frame is above the floor
  `EVAD_ASSERT_IMP(a_prob_energy, out_valid_o && (probability_o != '0), energy_out_o > noise_out_o)

  // each sample is squared and accumulated before the next, so ready drops right after a take
  `EVAD_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind energy_vad_hangover_top evad_checker u_evad_checker (.*);
